>>> hw/rtl/mctm_pkg.sv
// shared definitions for the multi channel pulse timer
// action codes, channel status layout, drive request type and default sizes
package mctm_pkg;

  localparam int DEF_CHANNELS   = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int LEVEL_BITS     = 16;
  localparam int ACTION_BITS    = 4;
  localparam int CHAN_BITS      = 4;
  localparam int VALUE_BITS     = 16;

  localparam logic [ACTION_BITS-1:0] ACT_TICK    = 4'd0;
  localparam logic [ACTION_BITS-1:0] ACT_START   = 4'd1;
  localparam logic [ACTION_BITS-1:0] ACT_STOP    = 4'd2;
  localparam logic [ACTION_BITS-1:0] ACT_RESET   = 4'd3;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR   = 4'd4;
  localparam logic [ACTION_BITS-1:0] ACT_SET_HI  = 4'd5;
  localparam logic [ACTION_BITS-1:0] ACT_SET_LO  = 4'd6;
  localparam logic [ACTION_BITS-1:0] ACT_MODE    = 4'd7;
  localparam logic [ACTION_BITS-1:0] ACT_MONO    = 4'd8;
  localparam logic [ACTION_BITS-1:0] ACT_REPEAT  = 4'd9;
  localparam logic [ACTION_BITS-1:0] ACT_UFLAG   = 4'd10;
  localparam logic [ACTION_BITS-1:0] ACT_CFLAG   = 4'd11;
  localparam logic [ACTION_BITS-1:0] ACT_ATTACH  = 4'd12;

  typedef struct packed {
    logic att;
    logic mono;
    logic cflg;
    logic uflg;
    logic lrun;
    logic hrun;
    logic en;
  } status_t;

  typedef struct packed {
    logic en;
    logic level;
  } drive_t;

endpackage

>>> hw/rtl/multi_channel_pulse_timer_top.sv
// multi channel pulse timer: channel entries in one ram, read-modify-write per request
// depends on mctm_pkg, mctm_ram, mctm_chan
// command request: read on accept, then modify/write; a no-entry request skips both
// tick request: all channels in turn, one channel entry a cycle through the ram ports
// one request in work at a time; the next is taken while a result waits to be taken
// reset is synchronous; entry valid bits make every channel read as zero after reset
module multi_channel_pulse_timer_top import mctm_pkg::*; #(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_BITS-1:0] action,
  input  logic [CHAN_BITS-1:0]   channel,
  input  logic [VALUE_BITS-1:0]  value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   flag_read,
  output logic [LEVEL_BITS-1:0]  output_levels,
  output logic                   tick_done
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = 4 * COUNT_BITS + $bits(status_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMD  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt_hi;
    logic [COUNT_BITS-1:0] cnt_lo;
    logic [COUNT_BITS-1:0] sp_hi;
    logic [COUNT_BITS-1:0] sp_lo;
    status_t               st;
  } entry_t;

  logic [1:0]             state;
  logic [ACTION_BITS-1:0] act;
  logic [IW-1:0]          chan;
  logic [VALUE_BITS-1:0]  val;
  logic [IW:0]            rd_idx;
  logic                   pend;
  logic [IW-1:0]          wr_idx;
  logic                   rd_ok;
  logic [CHANNELS-1:0]    ent_valid;
  logic [LEVEL_BITS-1:0]  levels;
  logic [LEVEL_BITS-1:0]  levels_next;
  logic                   flag;
  logic                   done;

  logic                   accept;
  logic                   cmd_ok;
  logic                   re;
  logic [IW-1:0]          raddr;
  logic                   we;
  logic [IW-1:0]          waddr;
  logic [EW-1:0]          rdata;
  entry_t                 ent_rd;
  entry_t                 ent_cmd;
  entry_t                 ent_tick;
  entry_t                 ent_wr;
  logic [COUNT_BITS-1:0]  tick_cnt_hi;
  logic [COUNT_BITS-1:0]  tick_cnt_lo;
  status_t                tick_st;
  logic                   flag_next;
  logic [COUNT_BITS-1:0]  sp_val;
  drive_t                 drv;
  logic [LEVEL_BITS-1:0]  lvl_bit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cmd_ok   = ({4'b0, channel} < 8'(CHANNELS)) && (action <= ACT_ATTACH);
  assign sp_val   = COUNT_BITS'(val);
  assign ent_rd   = rd_ok ? entry_t'(rdata) : '0;

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (state == S_IDLE) begin
      re    = accept && cmd_ok && (action != ACT_TICK);
      raddr = cmd_ok ? IW'(channel) : '0;
    end else if (state == S_TICK) begin
      re    = (rd_idx < (IW+1)'(CHANNELS));
      raddr = rd_idx[IW-1:0];
    end
  end

  always_comb begin
    ent_cmd   = ent_rd;
    flag_next = 1'b0;
    unique case (act)
      ACT_START: begin
        ent_cmd.st.hrun = 1'b1;
        ent_cmd.st.en   = 1'b1;
      end
      ACT_STOP: ent_cmd.st.en = 1'b0;
      ACT_RESET: begin
        ent_cmd.st.en   = 1'b0;
        ent_cmd.st.lrun = 1'b0;
        ent_cmd.st.uflg = 1'b0;
        ent_cmd.st.cflg = 1'b0;
        ent_cmd.st.mono = 1'b0;
        ent_cmd.cnt_hi  = '0;
        ent_cmd.cnt_lo  = '0;
        ent_cmd.sp_hi   = '0;
        ent_cmd.sp_lo   = '0;
      end
      ACT_CLEAR: begin
        ent_cmd.st.uflg = 1'b0;
        ent_cmd.st.cflg = 1'b0;
        ent_cmd.st.mono = 1'b0;
        ent_cmd.cnt_hi  = '0;
        ent_cmd.cnt_lo  = '0;
      end
      ACT_SET_HI: ent_cmd.sp_hi = sp_val;
      ACT_SET_LO: ent_cmd.sp_lo = sp_val;
      ACT_MODE: ent_cmd.st.mono = val[0];
      ACT_MONO: begin
        ent_cmd.sp_hi   = sp_val;
        ent_cmd.st.mono = 1'b1;
        ent_cmd.st.hrun = 1'b1;
        ent_cmd.st.en   = 1'b1;
      end
      ACT_REPEAT: begin
        ent_cmd.sp_hi = sp_val;
        ent_cmd.sp_lo = '0;
      end
      ACT_UFLAG: begin
        flag_next       = ent_rd.st.uflg;
        ent_cmd.st.uflg = 1'b0;
      end
      ACT_CFLAG: begin
        flag_next       = ent_rd.st.cflg;
        ent_cmd.st.cflg = 1'b0;
      end
      ACT_ATTACH: ent_cmd.st.att = val[0];
      default: ent_cmd = ent_rd;
    endcase
  end

  mctm_chan #(.COUNT_BITS(COUNT_BITS)) u_chan (
    .cnt_hi      (ent_rd.cnt_hi),
    .cnt_lo      (ent_rd.cnt_lo),
    .sp_hi       (ent_rd.sp_hi),
    .sp_lo       (ent_rd.sp_lo),
    .st          (ent_rd.st),
    .cnt_hi_next (tick_cnt_hi),
    .cnt_lo_next (tick_cnt_lo),
    .st_next     (tick_st),
    .drv         (drv)
  );
  assign ent_tick = {tick_cnt_hi, tick_cnt_lo, ent_rd.sp_hi, ent_rd.sp_lo, tick_st};

  always_comb begin
    we     = 1'b0;
    waddr  = chan;
    ent_wr = ent_cmd;
    if (state == S_CMD) begin
      we = 1'b1;
    end else if (state == S_TICK) begin
      we     = pend;
      waddr  = wr_idx;
      ent_wr = ent_tick;
    end
  end

  assign lvl_bit = LEVEL_BITS'(1) << wr_idx;

  always_comb begin
    levels_next = levels;
    if ((state == S_TICK) && pend && drv.en) begin
      levels_next = drv.level ? (levels | lvl_bit) : (levels & ~lvl_bit);
    end
  end

  mctm_ram #(.WIDTH(EW), .DEPTH(CHANNELS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (ent_wr),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ent_valid <= '0;
      levels    <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      rd_idx    <= '0;
    end else begin
      levels <= levels_next;
      if (we) begin
        ent_valid[waddr] <= 1'b1;
      end
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == ACT_TICK) begin
              state  <= S_TICK;
              rd_idx <= '0;
              pend   <= 1'b0;
            end else if (cmd_ok) begin
              state <= S_CMD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CMD: state <= S_FIN;
        S_TICK: begin
          pend <= re;
          if (re) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (!re && pend) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_ok  <= ent_valid[raddr];
      wr_idx <= raddr;
    end
    if (accept) begin
      act  <= action;
      chan <= IW'(channel);
      val  <= value;
      flag <= 1'b0;
      done <= (action == ACT_TICK);
    end
    if (state == S_CMD) begin
      flag <= flag_next;
    end
    if ((state == S_FIN) && (!out_valid || out_ready)) begin
      flag_read     <= flag;
      tick_done     <= done;
      output_levels <= levels;
    end
  end

endmodule

>>> hw/rtl/mctm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mctm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mctm_chan.sv
// tick service of one channel entry: phase counting and output drive request
// depends on mctm_pkg
module mctm_chan import mctm_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic [COUNT_BITS-1:0] cnt_hi,
  input  logic [COUNT_BITS-1:0] cnt_lo,
  input  logic [COUNT_BITS-1:0] sp_hi,
  input  logic [COUNT_BITS-1:0] sp_lo,
  input  status_t               st,
  output logic [COUNT_BITS-1:0] cnt_hi_next,
  output logic [COUNT_BITS-1:0] cnt_lo_next,
  output status_t               st_next,
  output drive_t                drv
);

  logic [COUNT_BITS:0] hi_inc;
  logic [COUNT_BITS:0] lo_inc;

  assign hi_inc = {1'b0, cnt_hi} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign lo_inc = {1'b0, cnt_lo} + {{COUNT_BITS{1'b0}}, 1'b1};

  always_comb begin
    cnt_hi_next = cnt_hi;
    cnt_lo_next = cnt_lo;
    st_next     = st;
    drv         = '0;
    if (st.en && (sp_hi != '0)) begin
      if (st.hrun) begin
        drv.en = st.att;
        if (hi_inc < {1'b0, sp_hi}) begin
          cnt_hi_next = hi_inc[COUNT_BITS-1:0];
          drv.level   = 1'b1;
        end else begin
          cnt_hi_next  = '0;
          st_next.hrun = 1'b0;
          st_next.uflg = 1'b1;
          st_next.cflg = 1'b1;
          st_next.lrun = 1'b1;
          drv.level    = 1'b0;
        end
      end else if (!st.mono && st.lrun) begin
        if (lo_inc < {1'b0, sp_lo}) begin
          cnt_lo_next = lo_inc[COUNT_BITS-1:0];
        end else begin
          drv.en       = st.att;
          drv.level    = 1'b1;
          cnt_lo_next  = '0;
          st_next.lrun = 1'b0;
          st_next.hrun = 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/mctm_checker.sv
// port level checks for the multi channel pulse timer, bound to the top level
// depends on mctm_pkg and multi_channel_pulse_timer_top
module mctm_checker import mctm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [ACTION_BITS-1:0] action,
  input logic [CHAN_BITS-1:0]   channel,
  input logic [VALUE_BITS-1:0]  value,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   flag_read,
  input logic [LEVEL_BITS-1:0]  output_levels,
  input logic                   tick_done
);

  // a result waiting to be taken holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(flag_read) && $stable(tick_done)
      && $stable(output_levels))
    else $error("result changed while stalled");

  // one request in work at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // a result comes from either a tick or a flag read, not both
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tick_done && flag_read))
    else $error("tick result carries a flag");

  // a tick request does not finish right after it is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_TICK) |=> !out_valid || $past(out_valid))
    else $error("tick result too early");

endmodule

bind multi_channel_pulse_timer_top mctm_checker u_mctm_checker (.*);

>>> bench/multi_channel_pulse_timer_checker.sv
// result checker for the multi channel pulse timer: tracks every accepted request,
// keeps its own copy of the channel bank and compares each result in order
// depends on mctm_pkg
module multi_channel_pulse_timer_checker import mctm_pkg::*; #(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [ACTION_BITS-1:0] action,
  input  logic [CHAN_BITS-1:0]   channel,
  input  logic [VALUE_BITS-1:0]  value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   flag_read,
  input  logic [LEVEL_BITS-1:0]  output_levels,
  input  logic                   tick_done,
  output int                     fail_count,
  output int                     pending
);

  localparam logic [31:0] SETPOINT_MASK = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                  flag;
    logic [LEVEL_BITS-1:0] levels;
    logic                  done;
  } timer_snapshot_t;

  logic [31:0]           hi_count [CHANNELS];
  logic [31:0]           lo_count [CHANNELS];
  logic [31:0]           hi_setpoint [CHANNELS];
  logic [31:0]           lo_setpoint [CHANNELS];
  status_t               chan_status [CHANNELS];
  logic [LEVEL_BITS-1:0] level_bits;

  timer_snapshot_t timer_snapshots[$];
  timer_snapshot_t want;
  int              mismatch_count;

  initial begin
    fail_count = 0;
    pending = 0;
    mismatch_count = 0;
  end

  // detached channels keep their last level
  function automatic void set_level(input int c, input logic lvl);
    if (chan_status[c].att && c < LEVEL_BITS) begin
      level_bits[c] = lvl;
    end
  endfunction

  function automatic timer_snapshot_t apply_timer_action(
    input logic [ACTION_BITS-1:0] act,
    input logic [CHAN_BITS-1:0]   chn,
    input logic [VALUE_BITS-1:0]  val
  );
    timer_snapshot_t snap;
    status_t         st;
    logic [31:0]     sp;
    int              c;
    snap = '0;
    sp = 32'(val) & SETPOINT_MASK;
    c = int'(chn);
    if (act == ACT_TICK) begin
      for (int k = 0; k < CHANNELS; k++) begin
        st = chan_status[k];
        if (st.en && hi_setpoint[k] != 32'd0) begin
          if (st.hrun) begin
            if ({1'b0, hi_count[k]} + 33'd1 < {1'b0, hi_setpoint[k]}) begin
              hi_count[k] = hi_count[k] + 32'd1;
              set_level(k, 1'b1);
            end else begin
              hi_count[k] = 32'd0;
              st.hrun = 1'b0;
              st.uflg = 1'b1;
              st.cflg = 1'b1;
              st.lrun = 1'b1;
              chan_status[k] = st;
              set_level(k, 1'b0);
            end
          end else if (!st.mono && st.lrun) begin
            if ({1'b0, lo_count[k]} + 33'd1 < {1'b0, lo_setpoint[k]}) begin
              lo_count[k] = lo_count[k] + 32'd1;
            end else begin
              set_level(k, 1'b1);
              lo_count[k] = 32'd0;
              st.lrun = 1'b0;
              st.hrun = 1'b1;
              chan_status[k] = st;
            end
          end
        end
      end
      snap.done = 1'b1;
    end else if (act <= ACT_ATTACH && c < CHANNELS) begin
      st = chan_status[c];
      case (act)
        ACT_START: begin
          st.hrun = 1'b1;
          st.en = 1'b1;
        end
        ACT_STOP: st.en = 1'b0;
        ACT_RESET: begin
          st.en = 1'b0;
          st.lrun = 1'b0;
          st.uflg = 1'b0;
          st.cflg = 1'b0;
          st.mono = 1'b0;
          hi_count[c] = 32'd0;
          lo_count[c] = 32'd0;
          hi_setpoint[c] = 32'd0;
          lo_setpoint[c] = 32'd0;
        end
        ACT_CLEAR: begin
          st.uflg = 1'b0;
          st.cflg = 1'b0;
          st.mono = 1'b0;
          hi_count[c] = 32'd0;
          lo_count[c] = 32'd0;
        end
        ACT_SET_HI: hi_setpoint[c] = sp;
        ACT_SET_LO: lo_setpoint[c] = sp;
        ACT_MODE: st.mono = val[0];
        ACT_MONO: begin
          hi_setpoint[c] = sp;
          st.mono = 1'b1;
          st.hrun = 1'b1;
          st.en = 1'b1;
        end
        ACT_REPEAT: begin
          hi_setpoint[c] = sp;
          lo_setpoint[c] = 32'd0;
        end
        ACT_UFLAG: begin
          snap.flag = st.uflg;
          st.uflg = 1'b0;
        end
        ACT_CFLAG: begin
          snap.flag = st.cflg;
          st.cflg = 1'b0;
        end
        default: st.att = val[0];
      endcase
      chan_status[c] = st;
    end
    snap.levels = level_bits;
    return snap;
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        hi_count[k] = 32'd0;
        lo_count[k] = 32'd0;
        hi_setpoint[k] = 32'd0;
        lo_setpoint[k] = 32'd0;
        chan_status[k] = '0;
      end
      level_bits = '0;
      timer_snapshots.delete();
    end else begin
      if (in_valid && in_ready) begin
        timer_snapshots.push_back(apply_timer_action(action, channel, value));
      end
      if (out_valid && out_ready) begin
        if (timer_snapshots.size() == 0) begin
          log_mismatch($sformatf("result with no request waiting: flag %b levels %h done %b",
                                 flag_read, output_levels, tick_done));
        end else begin
          want = timer_snapshots.pop_front();
          if (flag_read !== want.flag || output_levels !== want.levels ||
              tick_done !== want.done) begin
            log_mismatch($sformatf("expected flag %b levels %h done %b, got %b %h %b",
                                   want.flag, want.levels, want.done,
                                   flag_read, output_levels, tick_done));
          end
        end
      end
    end
    fail_count <= mismatch_count;
    pending <= timer_snapshots.size();
  end

endmodule

>>> bench/tb_multi_channel_pulse_timer_top.sv
// testbench top for the multi channel pulse timer: clock, reset, request stimulus
// with bursty sending and a stalling receiver, and the final verdict
// depends on mctm_pkg, multi_channel_pulse_timer_top, multi_channel_pulse_timer_checker
module tb_multi_channel_pulse_timer_top;
  import mctm_pkg::*;

  localparam int CHANNELS = DEF_CHANNELS;
  localparam int REQUEST_TARGET = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ACTION_BITS-1:0] ACT_FIRST_UNUSED = 4'd13;
  localparam logic [ACTION_BITS-1:0] ACT_LAST_UNUSED = 4'd15;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ACTION_BITS-1:0] action = ACT_TICK;
  logic [CHAN_BITS-1:0]   channel = '0;
  logic [VALUE_BITS-1:0]  value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   flag_read;
  logic [LEVEL_BITS-1:0]  output_levels;
  logic                   tick_done;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  multi_channel_pulse_timer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .channel      (channel),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .flag_read    (flag_read),
    .output_levels(output_levels),
    .tick_done    (tick_done)
  );

  multi_channel_pulse_timer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .channel      (channel),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .flag_read    (flag_read),
    .output_levels(output_levels),
    .tick_done    (tick_done),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // receiver: switches between free running, light, heavy and periodic stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cycle_count % 7) < 4;
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_request(input logic [ACTION_BITS-1:0] act,
                              input logic [CHAN_BITS-1:0] chn,
                              input logic [VALUE_BITS-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    channel <= chn;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_setpoint();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return VALUE_BITS'($urandom_range(0, 6));
    if (r < 85) return VALUE_BITS'($urandom_range(7, 40));
    if (r < 90) return '1;
    return VALUE_BITS'($urandom);
  endfunction

  initial begin
    int r;
    int n;
    logic [CHAN_BITS-1:0] ch;
    logic [VALUE_BITS-1:0] v;
    int next_drain;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // flag read straight after reset, widest setpoint on the top channel
    send_request(ACT_UFLAG, 4'd0, 16'h0000);
    send_request(ACT_SET_HI, 4'd15, 16'hFFFF);
    send_request(ACT_ATTACH, 4'd15, 16'hFFFF);
    send_request(ACT_START, 4'd15, 16'h0000);
    send_request(ACT_TICK, 4'd0, 16'h0000);
    // astable with zero low setpoint runs a one tick low phase
    send_request(ACT_ATTACH, 4'd0, 16'h0001);
    send_request(ACT_SET_HI, 4'd0, 16'h0002);
    send_request(ACT_SET_LO, 4'd0, 16'h0000);
    send_request(ACT_START, 4'd0, 16'h0000);
    send_request(ACT_TICK, 4'd9, 16'hFFFF);
    send_request(ACT_TICK, 4'd0, 16'h0000);
    send_request(ACT_TICK, 4'd0, 16'h0000);
    send_request(ACT_UFLAG, 4'd0, 16'h0000);
    send_request(ACT_CFLAG, 4'd0, 16'h0000);
    // monostable end leaves the output low
    send_request(ACT_ATTACH, 4'd1, 16'h0001);
    send_request(ACT_MONO, 4'd1, 16'h0001);
    send_request(ACT_TICK, 4'd0, 16'h0000);
    // detached channel keeps its level
    send_request(ACT_ATTACH, 4'd0, 16'hFFFE);
    send_request(ACT_TICK, 4'd0, 16'h0000);
    send_request(ACT_RESET, 4'd0, 16'h0000);
    send_request(ACT_CLEAR, 4'd1, 16'h0000);
    send_request(ACT_STOP, 4'd15, 16'h0000);
    send_request(ACT_MODE, 4'd2, 16'h0001);
    send_request(ACT_REPEAT, 4'd3, 16'hFFFF);
    for (int k = ACT_FIRST_UNUSED; k <= ACT_LAST_UNUSED; k++) begin
      send_request(ACTION_BITS'(k), CHAN_BITS'($urandom), VALUE_BITS'($urandom));
    end

    next_drain = 300;
    while (sent_count < REQUEST_TARGET) begin
      if (sent_count >= next_drain) begin
        drain_results();
        next_drain = next_drain + 300;
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // channel set-up followed by ticks, flag reads mixed in
        ch = CHAN_BITS'($urandom);
        send_request(ACT_SET_HI, ch, pick_setpoint());
        if ($urandom_range(0, 1) == 0) send_request(ACT_SET_LO, ch, pick_setpoint());
        v = VALUE_BITS'($urandom);
        v[0] = ($urandom_range(0, 7) != 0);
        send_request(ACT_ATTACH, ch, v);
        case ($urandom_range(0, 2))
          0: send_request(ACT_START, ch, VALUE_BITS'($urandom));
          1: send_request(ACT_MONO, ch, pick_setpoint());
          default: begin
            send_request(ACT_REPEAT, ch, pick_setpoint());
            send_request(ACT_START, ch, VALUE_BITS'($urandom));
          end
        endcase
        if ($urandom_range(0, 4) == 0) send_request(ACT_MODE, ch, VALUE_BITS'($urandom));
        n = $urandom_range(1, 10);
        repeat (n) begin
          send_request(ACT_TICK, CHAN_BITS'($urandom), VALUE_BITS'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            send_request(($urandom_range(0, 1) == 0) ? ACT_UFLAG : ACT_CFLAG, ch,
                         VALUE_BITS'($urandom));
          end
        end
      end else if (r < 70) begin
        send_request(ACT_TICK, CHAN_BITS'($urandom), VALUE_BITS'($urandom));
      end else if (r < 97) begin
        v = ($urandom_range(0, 1) == 0) ? pick_setpoint() : VALUE_BITS'($urandom);
        send_request(ACTION_BITS'($urandom_range(ACT_START, ACT_ATTACH)),
                     CHAN_BITS'($urandom), v);
      end else begin
        send_request(ACTION_BITS'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED)),
                     CHAN_BITS'($urandom), VALUE_BITS'($urandom));
      end
    end

    drain_results();
    repeat (CHANNELS + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
